// File: sv/sfda_pkg.sv
// ----------------------------------------------------------------------------
// sfda_pkg: shared types, constants and table builder
// Register map, configuration bundle and the sine table generator used at
// elaboration by the front end.
// ----------------------------------------------------------------------------
`default_nettype none

package sfda_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_PHASE_W = 24;
  localparam int DT_W        = 16;
  localparam int TABLE_W     = 16;
  localparam int ACC_W       = 48;
  localparam int RESULT_W    = 32;
  localparam int SCALE_SPLIT = 32;
  localparam int V_W         = ACC_W + DT_W + 1;

  localparam int MID_QUEUE_DEPTH = 4;
  localparam int OUT_QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_MODE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DT_SCALE     = 2'd3;

  localparam logic [DT_W-1:0] DT_RESET = 16'hFFFF;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic signed [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};
  localparam logic [V_W-1:0] ROUND_HALF = {{(V_W-31){1'b0}}, 1'b1, 30'd0};

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [CFG_PHASE_W-1:0] phase_step;
    logic [CFG_PHASE_W-1:0] start_phase;
    logic                   inverse_mode;
    logic [DT_W-1:0]        dt_scale;
  } cfg_t;

  typedef struct packed {
    logic                   load;
    logic [CFG_PHASE_W-1:0] value;
  } phase_load_t;

  // Q30 Taylor series on the first quarter wave, scaled to Q1.15
  function automatic logic [TABLE_W-1:0] quarter_sine(input logic [31:0] j,
                                                      input int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        scaled;
    x = (PI_Q30 * 64'd2 * 64'(j)) >> abits;
    term = x;
    acc = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      unique case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        7: term = term / 210;
        default: term = term;
      endcase
      if (n[0]) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    scaled = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    return scaled[TABLE_W-1:0];
  endfunction

  function automatic logic signed [TABLE_W-1:0] sine_entry(input int unsigned k,
                                                           input int unsigned abits);
    logic [31:0] q;
    logic [31:0] r;
    logic [1:0]  quad;
    logic signed [TABLE_W-1:0] v;
    q    = 32'd1 << (abits - 2);
    quad = 2'((k >> (abits - 2)) & 3);
    r    = k & (q - 32'd1);
    unique case (quad)
      2'd0: v = signed'(quarter_sine(r, abits));
      2'd1: v = signed'(quarter_sine(q - r, abits));
      2'd2: v = -signed'(quarter_sine(r, abits));
      2'd3: v = -signed'(quarter_sine(q - r, abits));
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/sfda_queue.sv
// ----------------------------------------------------------------------------
// sfda_queue: small register queue
// First-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sfda_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a transfer in");

endmodule

`default_nettype wire

// File: sv/sfda_front.sv
// ----------------------------------------------------------------------------
// sfda_front: phase generation and sine table lookup
// Takes samples, advances the phase and reads sine and cosine from the table.
// ----------------------------------------------------------------------------
`default_nettype none

module sfda_front #(
  parameter int PHASE_BITS      = 24,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sfda_pkg::cfg_t                cfg,
  input  wire sfda_pkg::phase_load_t         phase_load,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_real,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_imag,
  input  wire logic                          last_sample,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [2*SAMPLE_BITS+2*sfda_pkg::TABLE_W:0] q_data
);
  import sfda_pkg::*;

  localparam int TAB_N = 1 << TABLE_ADDR_BITS;
  localparam logic [TABLE_ADDR_BITS-1:0] QUARTER = TABLE_ADDR_BITS'(TAB_N / 4);

  logic signed [TABLE_W-1:0] sine_rom [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_rom
    localparam logic signed [TABLE_W-1:0] ENTRY = sine_entry(k, TABLE_ADDR_BITS);
    assign sine_rom[k] = ENTRY;
  end

  logic [PHASE_BITS-1:0]      phase_acc;
  logic [PHASE_BITS-1:0]      step_p;
  logic [TABLE_ADDR_BITS-1:0] sin_idx;
  logic [TABLE_ADDR_BITS-1:0] cos_idx;
  logic                       accept;

  logic                          valid1;
  logic                          last1;
  logic signed [SAMPLE_BITS-1:0] a1;
  logic signed [SAMPLE_BITS-1:0] b1;
  logic signed [TABLE_W-1:0]     sin1;
  logic signed [TABLE_W-1:0]     cos1;
  logic signed [TABLE_W-1:0]     s_eff;

  if (PHASE_BITS >= TABLE_ADDR_BITS) begin : g_idx_trunc
    assign sin_idx = phase_acc[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  end else begin : g_idx_pad
    assign sin_idx = {phase_acc, {(TABLE_ADDR_BITS-PHASE_BITS){1'b0}}};
  end

  assign cos_idx = sin_idx + QUARTER;
  assign step_p  = PHASE_BITS'(cfg.phase_step);
  assign full    = valid1 && q_full;
  assign accept  = push && !full;
  assign q_push  = valid1 && !q_full;

  // forward transform uses the conjugate phasor
  assign s_eff  = cfg.inverse_mode ? sin1 : -sin1;
  assign q_data = {last1, a1, b1, cos1, s_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      valid1    <= 1'b0;
    end else begin
      if (phase_load.load) begin
        phase_acc <= PHASE_BITS'(phase_load.value);
      end else if (accept) begin
        phase_acc <= last_sample ? PHASE_BITS'(cfg.start_phase) : phase_acc + step_p;
      end
      if (accept) begin
        valid1 <= 1'b1;
      end else if (q_push) begin
        valid1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a1    <= sample_real;
      b1    <= sample_imag;
      last1 <= last_sample;
      sin1  <= sine_rom[sin_idx];
      cos1  <= sine_rom[cos_idx];
    end
  end

endmodule

`default_nettype wire

// File: sv/sfda_back.sv
// ----------------------------------------------------------------------------
// sfda_back: complex multiply-accumulate and output scaling
// Rotates each sample, accumulates with 48-bit saturation and scales the
// final sum by dt_scale with rounding and 32-bit clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module sfda_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [sfda_pkg::DT_W-1:0]             dt_scale,
  input  wire logic                                  q_empty,
  input  wire logic [2*SAMPLE_BITS+2*sfda_pkg::TABLE_W:0] q_data,
  output logic                                       q_pop,
  input  wire logic                                  out_full,
  output logic                                       out_push,
  output logic [2*sfda_pkg::RESULT_W:0]              out_data
);
  import sfda_pkg::*;

  localparam int PW = SAMPLE_BITS + TABLE_W;
  localparam int HW = ACC_W - SCALE_SPLIT + DT_W + 1;
  localparam int LW = SCALE_SPLIT + DT_W;
  localparam int QW = V_W - 31;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] s,
                                                      input logic signed [PW:0] d);
    logic signed [ACC_W:0] t;
    t = (ACC_W+1)'(s) + (ACC_W+1)'(d);
    if (t[ACC_W] != t[ACC_W-1]) begin
      return t[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return t[ACC_W-1:0];
  endfunction

  function automatic logic signed [RESULT_W-1:0] clip32(input logic signed [QW-1:0] q);
    if (&q[QW-1:RESULT_W-1] || ~|q[QW-1:RESULT_W-1]) begin
      return q[RESULT_W-1:0];
    end
    return q[QW-1] ? RES_MIN : RES_MAX;
  endfunction

  logic                          adv;
  logic                          qlast;
  logic signed [SAMPLE_BITS-1:0] qa;
  logic signed [SAMPLE_BITS-1:0] qb;
  logic signed [TABLE_W-1:0]     qc;
  logic signed [TABLE_W-1:0]     qs;

  logic                 m_valid;
  logic                 m_last;
  logic signed [PW-1:0] p_ac;
  logic signed [PW-1:0] p_bs;
  logic signed [PW-1:0] p_as;
  logic signed [PW-1:0] p_bc;
  logic signed [PW:0]   d_real;
  logic signed [PW:0]   d_imag;

  logic signed [ACC_W-1:0] sum_real;
  logic signed [ACC_W-1:0] sum_imag;
  logic signed [ACC_W-1:0] sum_real_next;
  logic signed [ACC_W-1:0] sum_imag_next;

  logic                    s_valid;
  logic signed [ACC_W-1:0] sr;
  logic signed [ACC_W-1:0] si;

  logic                 p_valid;
  logic signed [HW-1:0] hr_p;
  logic signed [HW-1:0] hi_p;
  logic [LW-1:0]        lr_p;
  logic [LW-1:0]        li_p;

  logic signed [V_W-1:0]      vr;
  logic signed [V_W-1:0]      vi;
  logic signed [RESULT_W-1:0] res_real;
  logic signed [RESULT_W-1:0] res_imag;
  logic                       res_sat;

  assign {qlast, qa, qb, qc, qs} = q_data;

  assign adv      = !out_full;
  assign q_pop    = adv && !q_empty;
  assign out_push = adv && p_valid;

  assign d_real = {p_ac[PW-1], p_ac} - {p_bs[PW-1], p_bs};
  assign d_imag = {p_as[PW-1], p_as} + {p_bc[PW-1], p_bc};
  assign sum_real_next = sat_add(sum_real, d_real);
  assign sum_imag_next = sat_add(sum_imag, d_imag);

  // floor((sum * dt + 2^30) / 2^31) from the split partial products
  assign vr = {hr_p, {SCALE_SPLIT{1'b0}}} + {{(V_W-LW){1'b0}}, lr_p} + ROUND_HALF;
  assign vi = {hi_p, {SCALE_SPLIT{1'b0}}} + {{(V_W-LW){1'b0}}, li_p} + ROUND_HALF;

  assign res_real = clip32(vr[V_W-1:31]);
  assign res_imag = clip32(vi[V_W-1:31]);
  assign res_sat  = (res_real != vr[RESULT_W+30:31]) || (res_imag != vi[RESULT_W+30:31]) ||
                    !(&vr[V_W-1:RESULT_W+30] || ~|vr[V_W-1:RESULT_W+30]) ||
                    !(&vi[V_W-1:RESULT_W+30] || ~|vi[V_W-1:RESULT_W+30]);
  assign out_data = {res_real, res_imag, res_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      s_valid  <= 1'b0;
      p_valid  <= 1'b0;
      sum_real <= '0;
      sum_imag <= '0;
    end else if (adv) begin
      m_valid <= !q_empty;
      s_valid <= m_valid && m_last;
      p_valid <= s_valid;
      if (m_valid) begin
        if (m_last) begin
          sum_real <= '0;
          sum_imag <= '0;
        end else begin
          sum_real <= sum_real_next;
          sum_imag <= sum_imag_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_last <= qlast;
      p_ac   <= qa * qc;
      p_bs   <= qb * qs;
      p_as   <= qa * qs;
      p_bc   <= qb * qc;
    end
    if (adv && m_valid && m_last) begin
      sr <= sum_real_next;
      si <= sum_imag_next;
    end
    if (adv && s_valid) begin
      hr_p <= $signed(sr[ACC_W-1:SCALE_SPLIT]) * $signed({1'b0, dt_scale});
      hi_p <= $signed(si[ACC_W-1:SCALE_SPLIT]) * $signed({1'b0, dt_scale});
      lr_p <= sr[SCALE_SPLIT-1:0] * dt_scale;
      li_p <= si[SCALE_SPLIT-1:0] * dt_scale;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    adv && m_valid && m_last |=> sum_real == '0 && sum_imag == '0)
    else $error("sums not cleared after final sample");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sum_real) && $stable(sum_imag) && $stable(p_valid))
    else $error("back end moved while stalled");

  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !out_full && !q_empty)
    else $error("item taken from queue without room downstream");

endmodule

`default_nettype wire

// File: sv/single_frequency_dft_accumulator.sv
// ----------------------------------------------------------------------------
// single_frequency_dft_accumulator: single-bin DFT accumulator
// Sums samples times a unit phasor and emits the scaled sum on the final
// sample of each block.
// ----------------------------------------------------------------------------
// Sustains one sample per clock while the result queue has room: the front
// end advances the phase and reads sine and cosine from a synchronous table
// of 2^TABLE_ADDR_BITS entries, a four-entry queue decouples it from the back
// end, which does four parallel multiplies and one saturating 48-bit
// accumulate per cycle. A block's result passes the product, sum and scaling
// registers and waits in a two-entry result queue; while that queue is full
// the back end holds and the input side fills up. There is no clearing pass
// after reset. Registers take effect at once and should be written only with
// no sample in flight; writing start_phase also reloads the phase.
`default_nettype none

module single_frequency_dft_accumulator #(
  parameter int PHASE_BITS      = 24,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_real,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_imag,
  input  wire logic                                  last_sample,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic signed [sfda_pkg::RESULT_W-1:0]       result_real,
  output logic signed [sfda_pkg::RESULT_W-1:0]       result_imag,
  output logic                                       saturated,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [sfda_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [sfda_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import sfda_pkg::*;

  localparam int ITEM_W = 2 * SAMPLE_BITS + 2 * TABLE_W + 1;
  localparam int RES_W  = 2 * RESULT_W + 1;

  cfg_t        cfg;
  phase_load_t phase_load;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  logic [ITEM_W-1:0] q_wr_data;
  logic [ITEM_W-1:0] q_rd_data;

  logic             out_push;
  logic             out_full;
  logic [RES_W-1:0] out_wr_data;
  logic [RES_W-1:0] out_rd_data;

  assign cfg_ready        = 1'b1;
  assign phase_load.load  = cfg_valid && (cfg_index == REG_START_PHASE);
  assign phase_load.value = cfg_data[CFG_PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= '0;
      cfg.start_phase  <= '0;
      cfg.inverse_mode <= 1'b0;
      cfg.dt_scale     <= DT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   cfg.phase_step   <= cfg_data[CFG_PHASE_W-1:0];
        REG_START_PHASE:  cfg.start_phase  <= cfg_data[CFG_PHASE_W-1:0];
        REG_INVERSE_MODE: cfg.inverse_mode <= cfg_data[0];
        REG_DT_SCALE:     cfg.dt_scale     <= cfg_data[DT_W-1:0];
      endcase
    end
  end

  sfda_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .phase_load  (phase_load),
    .push        (push),
    .full        (full),
    .sample_real (sample_real),
    .sample_imag (sample_imag),
    .last_sample (last_sample),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  sfda_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_QUEUE_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  sfda_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .dt_scale (cfg.dt_scale),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (out_wr_data)
  );

  sfda_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (out_wr_data),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_rd_data),
    .empty   (empty)
  );

  assign {result_real, result_imag, saturated} = out_rd_data;

endmodule

`default_nettype wire
